>>> design/dttf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dttf_pkg
// Shared types, constants and single-precision helper functions for the
// decimal text to float parser.
// ---------------------------------------------------------------------------
package dttf_pkg;

    localparam int CountBits = 16;
    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;

    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_DOT  = 3'd1;
    localparam logic [2:0] OP_INT  = 3'd2;
    localparam logic [2:0] OP_FRAC = 3'd3;
    localparam logic [2:0] OP_EMIT = 3'd4;

    localparam logic [31:0] F_ONE   = 32'h3F800000;
    localparam logic [31:0] F_TEN   = 32'h41200000;
    localparam logic [31:0] F_TENTH = 32'h3DCCCCCD;
    localparam logic [31:0] F_DNAN  = 32'hFFC00000;

    localparam logic [25:0] CHi = 26'h3333333;
    localparam logic [26:0] CLo = 27'h199999A;

    typedef struct packed {
        logic [2:0]           op;
        logic                 clr;
        logic [3:0]           dig;
        logic [31:0]          exp;
        logic                 eneg;
        logic                 neg;
        logic                 zero;
        logic [CountBits-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic [23:0]        m;
        logic signed [11:0] e;
    } t_unp;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       fnd;
        n   = 5'd24;
        fnd = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!fnd && v[i]) begin
                n   = 5'(23 - i);
                fnd = 1'b1;
            end
        end
        return n;
    endfunction

    function automatic t_unp fp_unpack(input logic [31:0] f);
        t_unp       u;
        logic [23:0] mt;
        logic [4:0]  lz;
        mt = {1'b0, f[22:0]};
        lz = lzc24(mt);
        if (f[30:23] == 8'd0) begin
            u.m = mt << lz;
            u.e = 12'sd1 - $signed({7'd0, lz});
        end else begin
            u.m = {1'b1, f[22:0]};
            u.e = $signed({4'd0, f[30:23]});
        end
        return u;
    endfunction

    function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                             input logic [55:0] sig, input logic st);
        logic [6:0]  sh;
        logic [55:0] ss;
        logic        lost;
        logic [7:0]  ef;
        logic [23:0] m;
        logic        g;
        logic        r;
        logic        up;
        logic [30:0] body;
        if (e >= 12'sd255) begin
            return {s, 8'hFF, 23'd0};
        end
        if (e <= 12'sd0) begin
            if (e < -12'sd55) begin
                sh = 7'd57;
            end else begin
                sh = 7'(12'sd1 - e);
            end
            ef = 8'd0;
        end else begin
            sh = 7'd0;
            ef = e[7:0];
        end
        ss   = sig >> sh;
        lost = |(sig & ~({56{1'b1}} << sh));
        m    = ss[55:32];
        g    = ss[31];
        r    = (|ss[30:0]) | st | lost;
        up   = g & (r | m[0]);
        body = {ef, m[22:0]} + {30'd0, up};
        return {s, body};
    endfunction

    function automatic logic [31:0] dig2f(input logic [3:0] d);
        logic [31:0] f;
        case (d)
            4'd1:    f = 32'h3F800000;
            4'd2:    f = 32'h40000000;
            4'd3:    f = 32'h40400000;
            4'd4:    f = 32'h40800000;
            4'd5:    f = 32'h40A00000;
            4'd6:    f = 32'h40C00000;
            4'd7:    f = 32'h40E00000;
            4'd8:    f = 32'h41000000;
            4'd9:    f = 32'h41100000;
            default: f = 32'h00000000;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

>>> design/dttf_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dttf_front
// Character classifier: tracks the parse phase, sign, position and exponent
// digits, and issues one arithmetic command per character that needs one.
// ---------------------------------------------------------------------------
module dttf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_ch,
    input  wire logic          i_start,
    output logic               o_ready,
    input  wire logic          i_full,
    output logic               o_push,
    output dttf_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WS    = 3'd1;
    localparam logic [2:0] PH_INT   = 3'd2;
    localparam logic [2:0] PH_FRAC  = 3'd3;
    localparam logic [2:0] PH_ESIGN = 3'd4;
    localparam logic [2:0] PH_EDIG  = 3'd5;

    localparam int Cb = dttf_pkg::CountBits;

    logic [2:0]    r_ph, n_ph;
    logic          r_neg, n_neg;
    logic          r_eneg, n_eneg;
    logic [31:0]   r_exp, n_exp;
    logic [Cb-1:0] r_pos, n_pos;

    logic          acc;
    logic          is_sp;
    logic          is_dg;
    logic [3:0]    d;
    logic [Cb-1:0] pos_inc;

    assign o_ready = !i_full;
    assign acc     = i_valid && !i_full;
    assign is_sp   = (i_ch == 8'd32) || (i_ch inside {[8'd9:8'd13]});
    assign is_dg   = i_ch inside {[8'd48:8'd57]};
    assign d       = 4'(i_ch - 8'd48);

    always_comb begin
        n_ph   = i_start ? PH_WS : r_ph;
        n_neg  = i_start ? 1'b0 : r_neg;
        n_eneg = i_start ? 1'b0 : r_eneg;
        n_exp  = i_start ? 32'd0 : r_exp;
        n_pos  = i_start ? '0 : r_pos;
        pos_inc = (&n_pos) ? n_pos : n_pos + 1'b1;
        o_push = i_start;
        o_cmd  = '0;
        o_cmd.clr = i_start;
        o_cmd.op  = dttf_pkg::OP_NOP;
        if (n_ph == PH_WS) begin
            if (is_sp) begin
                n_pos = pos_inc;
            end else if (i_ch == 8'd45) begin
                n_neg = 1'b1;
                n_pos = pos_inc;
                n_ph  = PH_INT;
            end else if (i_ch == 8'd43) begin
                n_pos = pos_inc;
                n_ph  = PH_INT;
            end else begin
                n_ph = PH_INT;
                pos_inc = (&n_pos) ? n_pos : n_pos + 1'b1;
                if (is_dg) begin
                    o_push    = 1'b1;
                    o_cmd.op  = dttf_pkg::OP_INT;
                    o_cmd.dig = d;
                    n_pos     = pos_inc;
                end else if (i_ch == 8'd46) begin
                    o_push   = 1'b1;
                    o_cmd.op = dttf_pkg::OP_DOT;
                    n_pos    = pos_inc;
                    n_ph     = PH_FRAC;
                end else if ((i_ch | 8'd32) == 8'd101) begin
                    n_exp  = 32'd0;
                    n_eneg = 1'b0;
                    n_pos  = pos_inc;
                    n_ph   = PH_ESIGN;
                end else begin
                    o_push    = 1'b1;
                    o_cmd.op  = dttf_pkg::OP_EMIT;
                    o_cmd.neg = n_neg;
                    o_cmd.cnt = n_pos;
                    n_ph      = PH_IDLE;
                end
            end
        end else if (n_ph == PH_INT || n_ph == PH_FRAC) begin
            if (is_dg) begin
                o_push    = 1'b1;
                o_cmd.op  = (n_ph == PH_INT) ? dttf_pkg::OP_INT : dttf_pkg::OP_FRAC;
                o_cmd.dig = d;
                n_pos     = pos_inc;
            end else if (i_ch == 8'd46 && n_ph == PH_INT) begin
                o_push   = 1'b1;
                o_cmd.op = dttf_pkg::OP_DOT;
                n_pos    = pos_inc;
                n_ph     = PH_FRAC;
            end else if ((i_ch | 8'd32) == 8'd101) begin
                n_exp  = 32'd0;
                n_eneg = 1'b0;
                n_pos  = pos_inc;
                n_ph   = PH_ESIGN;
            end else begin
                o_push    = 1'b1;
                o_cmd.op  = dttf_pkg::OP_EMIT;
                o_cmd.neg = n_neg;
                o_cmd.cnt = n_pos;
                n_ph      = PH_IDLE;
            end
        end else if (n_ph == PH_ESIGN) begin
            if (i_ch == 8'd45) begin
                n_eneg = 1'b1;
                n_pos  = pos_inc;
                n_ph   = PH_EDIG;
            end else if (i_ch == 8'd43) begin
                n_pos = pos_inc;
                n_ph  = PH_EDIG;
            end else if (is_dg) begin
                n_exp = {28'd0, d};
                n_pos = pos_inc;
                n_ph  = PH_EDIG;
            end else begin
                o_push     = 1'b1;
                o_cmd.op   = dttf_pkg::OP_EMIT;
                o_cmd.neg  = n_neg;
                o_cmd.zero = 1'b1;
                o_cmd.cnt  = '0;
                n_ph       = PH_IDLE;
            end
        end else if (n_ph == PH_EDIG) begin
            if (is_dg) begin
                n_exp = (n_exp << 3) + (n_exp << 1) + {28'd0, d};
                n_pos = pos_inc;
            end else begin
                o_push     = 1'b1;
                o_cmd.op   = dttf_pkg::OP_EMIT;
                o_cmd.neg  = n_neg;
                o_cmd.exp  = n_exp;
                o_cmd.eneg = n_eneg;
                o_cmd.cnt  = n_pos;
                n_ph       = PH_IDLE;
            end
        end else begin
            n_ph = PH_IDLE;
        end
        o_push = o_push && acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_neg  <= 1'b0;
            r_eneg <= 1'b0;
            r_exp  <= 32'd0;
            r_pos  <= '0;
        end else if (acc) begin
            r_ph   <= n_ph;
            r_neg  <= n_neg;
            r_eneg <= n_eneg;
            r_exp  <= n_exp;
            r_pos  <= n_pos;
        end
    end

endmodule
`default_nettype wire

>>> design/dttf_fifo.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dttf_fifo
// Short command queue between the classifier and the arithmetic sequencer.
// ---------------------------------------------------------------------------
module dttf_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  dttf_pkg::t_cmd      i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output dttf_pkg::t_cmd      o_cmd
);

    localparam int Aw = dttf_pkg::FifoAw;

    dttf_pkg::t_cmd r_mem [dttf_pkg::FifoDepth];
    logic [Aw-1:0]  r_wp;
    logic [Aw-1:0]  r_rp;
    logic [Aw:0]    r_cnt;
    logic           do_pop;

    assign o_full  = (r_cnt == (Aw+1)'(dttf_pkg::FifoDepth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + {{Aw{1'b0}}, i_push} - {{Aw{1'b0}}, do_pop};
        end
    end

endmodule
`default_nettype wire

>>> design/dttf_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dttf_back
// Arithmetic sequencer: single-precision multiply and add steps, the
// double-rounded tenth factor and the square-and-multiply exponent scaling.
// ---------------------------------------------------------------------------
module dttf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  dttf_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_m_tvalid,
    output logic [47:0]         o_m_tdata,
    input  wire logic           i_m_tready
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MA   = 4'd1;
    localparam logic [3:0] S_MB   = 4'd2;
    localparam logic [3:0] S_AA   = 4'd3;
    localparam logic [3:0] S_AB   = 4'd4;
    localparam logic [3:0] S_D0   = 4'd5;
    localparam logic [3:0] S_D1   = 4'd6;
    localparam logic [3:0] S_D2   = 4'd7;
    localparam logic [3:0] S_D3   = 4'd8;
    localparam logic [3:0] S_EX   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    localparam logic [1:0] K_INT_ADD  = 2'd0;
    localparam logic [1:0] K_FRAC_ADD = 2'd1;
    localparam logic [1:0] K_EXP_ACC  = 2'd2;
    localparam logic [1:0] K_EXP_SQ   = 2'd3;

    localparam int Cb = dttf_pkg::CountBits;

    logic [3:0]         r_st;
    logic [1:0]         r_after;
    logic [31:0]        r_acc;
    logic [31:0]        r_scl;
    logic [31:0]        r_a;
    logic [31:0]        r_b;
    logic [3:0]         r_dig;
    logic [47:0]        r_p;
    logic signed [11:0] r_pe;
    logic               r_ps;
    logic               r_pspec;
    logic [31:0]        r_pspv;
    logic [56:0]        r_sum;
    logic signed [11:0] r_se;
    logic               r_sst;
    logic               r_aspec;
    logic [31:0]        r_aspv;
    logic [23:0]        r_dm;
    logic signed [11:0] r_des;
    logic [49:0]        r_pp;
    logic [76:0]        r_pw;
    logic [52:0]        r_d;
    logic signed [11:0] r_de;
    logic [31:0]        r_e;
    logic [31:0]        r_f;
    logic               r_sqp;
    logic               r_neg;
    logic               r_zero;
    logic [Cb-1:0]      r_cnt;
    logic               r_ovalid;
    logic [47:0]        r_odata;

    dttf_pkg::t_unp ua;
    dttf_pkg::t_unp ub;
    logic           nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, psign;
    logic [47:0]    prod;
    logic [31:0]    mres;
    logic [31:0]    hi, lo;
    logic           hi_sp, lo_sp;
    logic [7:0]     ediff;
    logic [5:0]     dcap;
    logic [55:0]    vb, vbs;
    logic           vlost;
    logic [31:0]    ares;
    logic           dg, dst, dup;
    logic [52:0]    dd;
    logic signed [11:0] dex;
    logic [53:0]    dsum;
    logic [31:0]    sres;
    logic           out_ok;
    logic [31:0]    oval;
    dttf_pkg::t_unp us;

    assign o_pop      = (r_st == S_IDLE) && i_valid;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign out_ok     = !r_ovalid || i_m_tready;

    always_comb begin
        ua     = dttf_pkg::fp_unpack(r_a);
        ub     = dttf_pkg::fp_unpack(r_b);
        nan_a  = (&r_a[30:23]) && (|r_a[22:0]);
        nan_b  = (&r_b[30:23]) && (|r_b[22:0]);
        inf_a  = (&r_a[30:23]) && !(|r_a[22:0]);
        inf_b  = (&r_b[30:23]) && !(|r_b[22:0]);
        zero_a = (r_a[30:0] == 31'd0);
        zero_b = (r_b[30:0] == 31'd0);
        psign  = r_a[31] ^ r_b[31];
        prod   = ua.m * ub.m;
        if (r_p[47]) begin
            mres = dttf_pkg::fp_round(r_ps, r_pe + 12'sd1, {r_p, 8'd0}, 1'b0);
        end else begin
            mres = dttf_pkg::fp_round(r_ps, r_pe, {r_p[46:0], 9'd0}, 1'b0);
        end
        if (r_pspec) begin
            mres = r_pspv;
        end

        if (r_a[30:23] >= r_b[30:23]) begin
            hi = r_a;
            lo = r_b;
        end else begin
            hi = r_b;
            lo = r_a;
        end
        hi_sp = (hi[30:23] != 8'd0);
        lo_sp = (lo[30:23] != 8'd0);
        ediff = (hi_sp ? hi[30:23] : 8'd1) - (lo_sp ? lo[30:23] : 8'd1);
        dcap  = (ediff > 8'd56) ? 6'd56 : ediff[5:0];
        vb    = {lo_sp, lo[22:0], 32'd0};
        vbs   = vb >> dcap;
        vlost = |(vb & ~({56{1'b1}} << dcap));
        if (r_sum[56]) begin
            ares = dttf_pkg::fp_round(1'b0, r_se + 12'sd1, r_sum[56:1], r_sst | r_sum[0]);
        end else if (r_sum[55]) begin
            ares = dttf_pkg::fp_round(1'b0, r_se, r_sum[55:0], r_sst);
        end else begin
            ares = {9'd0, r_sum[54:32]};
        end
        if (r_aspec) begin
            ares = r_aspv;
        end

        if (r_pw[76]) begin
            dd  = r_pw[76:24];
            dg  = r_pw[23];
            dst = |r_pw[22:0];
            dex = r_des - 12'sd3;
        end else begin
            dd  = r_pw[75:23];
            dg  = r_pw[22];
            dst = |r_pw[21:0];
            dex = r_des - 12'sd4;
        end
        dup  = dg && (dst || dd[0]);
        dsum = {1'b0, dd} + {53'd0, dup};
        sres = dttf_pkg::fp_round(1'b0, r_de, {r_d, 3'd0}, 1'b0);
        us   = dttf_pkg::fp_unpack(r_scl);

        if (r_zero) begin
            oval = {r_neg, 31'd0};
        end else if ((&r_acc[30:23]) && (|r_acc[22:0])) begin
            oval = r_acc;
        end else begin
            oval = {r_acc[31] ^ r_neg, r_acc[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
            r_acc    <= 32'd0;
            r_scl    <= dttf_pkg::F_ONE;
        end else begin
            if (r_ovalid && i_m_tready && (r_st != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_dig  <= i_cmd.dig;
                        r_neg  <= i_cmd.neg;
                        r_zero <= i_cmd.zero;
                        r_cnt  <= i_cmd.cnt;
                        r_e    <= i_cmd.exp;
                        r_f    <= i_cmd.eneg ? dttf_pkg::F_TENTH : dttf_pkg::F_TEN;
                        r_sqp  <= 1'b0;
                        if (i_cmd.clr) begin
                            r_acc <= 32'd0;
                        end
                        if (i_cmd.clr || (i_cmd.op == dttf_pkg::OP_DOT)) begin
                            r_scl <= dttf_pkg::F_ONE;
                        end
                        case (i_cmd.op)
                            dttf_pkg::OP_INT: begin
                                r_a     <= i_cmd.clr ? 32'd0 : r_acc;
                                r_b     <= dttf_pkg::F_TEN;
                                r_after <= K_INT_ADD;
                                r_st    <= S_MA;
                            end
                            dttf_pkg::OP_FRAC: begin
                                if (r_scl[30:0] == 31'd0) begin
                                    r_a     <= dttf_pkg::dig2f(i_cmd.dig);
                                    r_b     <= 32'd0;
                                    r_after <= K_FRAC_ADD;
                                    r_st    <= S_MA;
                                end else begin
                                    r_dm  <= us.m;
                                    r_des <= us.e;
                                    r_st  <= S_D0;
                                end
                            end
                            dttf_pkg::OP_EMIT: begin
                                r_st <= i_cmd.zero ? S_OUT : S_EX;
                            end
                            default: begin
                                r_st <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MA: begin
                    r_p  <= prod;
                    r_pe <= ua.e + ub.e - 12'sd127;
                    r_ps <= psign;
                    r_pspec <= nan_a || nan_b || inf_a || inf_b || zero_a || zero_b;
                    if (nan_a) begin
                        r_pspv <= r_a | 32'h00400000;
                    end else if (nan_b) begin
                        r_pspv <= r_b | 32'h00400000;
                    end else if ((inf_a && zero_b) || (inf_b && zero_a)) begin
                        r_pspv <= dttf_pkg::F_DNAN;
                    end else if (inf_a || inf_b) begin
                        r_pspv <= {psign, 8'hFF, 23'd0};
                    end else begin
                        r_pspv <= {psign, 31'd0};
                    end
                    r_st <= S_MB;
                end
                S_MB: begin
                    case (r_after)
                        K_INT_ADD: begin
                            r_a  <= mres;
                            r_b  <= dttf_pkg::dig2f(r_dig);
                            r_st <= S_AA;
                        end
                        K_FRAC_ADD: begin
                            r_a  <= r_acc;
                            r_b  <= mres;
                            r_st <= S_AA;
                        end
                        K_EXP_ACC: begin
                            r_acc <= mres;
                            r_st  <= S_EX;
                        end
                        default: begin
                            r_f  <= mres;
                            r_st <= S_EX;
                        end
                    endcase
                end
                S_AA: begin
                    r_sum   <= {1'b0, hi_sp, hi[22:0], 32'd0} + {1'b0, vbs};
                    r_se    <= hi_sp ? $signed({4'd0, hi[30:23]}) : 12'sd1;
                    r_sst   <= vlost;
                    r_aspec <= nan_a || nan_b || inf_a || inf_b;
                    if (nan_a) begin
                        r_aspv <= r_a | 32'h00400000;
                    end else if (nan_b) begin
                        r_aspv <= r_b | 32'h00400000;
                    end else begin
                        r_aspv <= {1'b0, 8'hFF, 23'd0};
                    end
                    r_st <= S_AB;
                end
                S_AB: begin
                    r_acc <= ares;
                    r_st  <= S_IDLE;
                end
                S_D0: begin
                    r_pp <= r_dm * dttf_pkg::CHi;
                    r_st <= S_D1;
                end
                S_D1: begin
                    r_pw <= {r_pp, 27'd0} + (77'(r_dm) * 77'(dttf_pkg::CLo));
                    r_st <= S_D2;
                end
                S_D2: begin
                    if (dsum[53]) begin
                        r_d  <= dsum[53:1];
                        r_de <= dex + 12'sd1;
                    end else begin
                        r_d  <= dsum[52:0];
                        r_de <= dex;
                    end
                    r_st <= S_D3;
                end
                S_D3: begin
                    r_scl   <= sres;
                    r_a     <= dttf_pkg::dig2f(r_dig);
                    r_b     <= sres;
                    r_after <= K_FRAC_ADD;
                    r_st    <= S_MA;
                end
                S_EX: begin
                    if (!r_sqp) begin
                        r_sqp <= 1'b1;
                        if (r_e[0]) begin
                            r_a     <= r_acc;
                            r_b     <= r_f;
                            r_after <= K_EXP_ACC;
                            r_st    <= S_MA;
                        end
                    end else begin
                        r_sqp <= 1'b0;
                        r_e   <= r_e >> 1;
                        if ((r_e >> 1) == 32'd0) begin
                            r_st <= S_OUT;
                        end else begin
                            r_a     <= r_f;
                            r_b     <= r_f;
                            r_after <= K_EXP_SQ;
                            r_st    <= S_MA;
                        end
                    end
                end
                S_OUT: begin
                    if (out_ok) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {16'(r_cnt), oval};
                        r_st     <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> design/decimal_text_to_float_parser_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// decimal_text_to_float_parser_core
// Streams decimal text in, one character per item, and returns the parsed
// IEEE single value together with the end offset of the number.
// ---------------------------------------------------------------------------
// The classifier takes one character per cycle while its four-entry command
// queue has room; the arithmetic sequencer behind it sets the sustained rate.
// An integer digit costs one multiply and one add, each in two steps; a
// fraction digit forms the tenth factor first and then costs a multiply and
// an add, or only those once the factor has reached zero; other characters
// need no arithmetic step. The terminating character runs the exponent steps
// and the output step, or only the output step when a bad character follows
// the exponent letter; an exponent adds a multiply for each set bit and a
// squaring for each bit below the highest set one, 32 bits at most, through
// the shared multiplier. One result item is held in an output register, so
// the next string can be parsed while that result waits to be taken.
module decimal_text_to_float_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] ch
    input  wire logic        i_s_tuser,   // [0] start_req
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata    // [31:0] value_bits, [47:32] consumed
);

    logic           full;
    logic           push;
    logic           pop;
    logic           qvalid;
    dttf_pkg::t_cmd cmd_in;
    dttf_pkg::t_cmd cmd_out;

    dttf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_ch    (i_s_tdata),
        .i_start (i_s_tuser),
        .o_ready (o_s_tready),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd_in)
    );

    dttf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qvalid),
        .o_cmd   (cmd_out)
    );

    dttf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (qvalid),
        .i_cmd      (cmd_out),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .i_m_tready (i_m_tready)
    );

endmodule
`default_nettype wire

>>> verif/decimal_text_to_float_parser_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decimal_text_to_float_parser_core_tb
// Streams decimal strings into the parser one character per item and checks
// each result item against a bit-exact single-precision model of the parse.
// The directed strings cover signs, whitespace, fractions, exponents, bad
// exponent characters, dropped strings, overflow and underflow. Random
// strings follow, first with the sender idling lightly and the receiver
// heavily, then the reverse, then with no idling.
// ---------------------------------------------------------------------------
module decimal_text_to_float_parser_core_tb;

    typedef enum logic [2:0] {
        P_IDLE, P_WS, P_INT, P_FRAC, P_ESIGN, P_EDIG
    } t_parse_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       start;
    } t_char_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;   // [7:0] ch
    logic        i_s_tuser = 1'b0;   // [0] start_req
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [47:0] o_m_tdata;          // [31:0] value_bits, [47:32] consumed

    decimal_text_to_float_parser_core uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_char_item   pending_chars[$];
    logic [47:0]  expected_results[$];
    t_char_item   cur_char;
    int           errors = 0;
    int           accepted = 0;
    int           stage_len = 1000000;
    int           idle_mode = 0;

    t_parse_phase ph = P_IDLE;
    logic [31:0]  acc = 32'd0;
    logic [31:0]  fac = dttf_pkg::F_ONE;
    logic [31:0]  expo = 32'd0;
    logic         neg = 1'b0;
    logic [31:0]  pos = 32'd0;

    function automatic logic [31:0] round_pack(input logic s, input logic [127:0] v,
                                               input int ex);
        int          k;
        int          be;
        int          sh;
        logic [79:0] m;
        logic        st;
        logic        up;
        logic [30:0] body;
        if (v == 128'd0) return {s, 31'd0};
        k = 127;
        while (!v[k]) k--;
        if (k > 79) begin
            st = |(v & ((128'd1 << (k - 79)) - 128'd1));
            m  = 80'(v >> (k - 79));
        end else begin
            st = 1'b0;
            m  = 80'(v << (79 - k));
        end
        be = ex + k + 127;
        if (be >= 255) return {s, 8'hFF, 23'd0};
        if (be <= 0) begin
            sh = 1 - be;
            if (sh > 80) sh = 80;
            st = st | (|(m & ((80'd1 << sh) - 80'd1)));
            m  = (sh >= 80) ? 80'd0 : (m >> sh);
            be = 0;
        end
        st   = st | (|m[54:0]);
        up   = m[55] & (st | m[56]);
        body = {be[7:0], m[78:56]} + {30'd0, up};
        return {s, body};
    endfunction

    function automatic logic is_nan(input logic [31:0] f);
        return f[30:23] == 8'hFF && f[22:0] != 23'd0;
    endfunction

    function automatic logic is_inf(input logic [31:0] f);
        return f[30:0] == {8'hFF, 23'd0};
    endfunction

    function automatic logic [23:0] mant_of(input logic [31:0] f);
        return (f[30:23] == 8'd0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
    endfunction

    function automatic int exp_of(input logic [31:0] f);
        return (f[30:23] == 8'd0) ? -149 : int'(f[30:23]) - 150;
    endfunction

    function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return dttf_pkg::F_DNAN;
        if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0))
            return dttf_pkg::F_DNAN;
        if (is_inf(a) || is_inf(b)) return {s, 8'hFF, 23'd0};
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
        return round_pack(s, 128'(mant_of(a)) * 128'(mant_of(b)), exp_of(a) + exp_of(b));
    endfunction

    // Both operands are never negative in this parse.
    function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]  hi;
        logic [31:0]  lo;
        int           diff;
        logic [127:0] sum;
        if (is_nan(a) || is_nan(b)) return dttf_pkg::F_DNAN;
        if (is_inf(a) || is_inf(b)) return {1'b0, 8'hFF, 23'd0};
        if (a[30:0] == 31'd0) return b;
        if (b[30:0] == 31'd0) return a;
        hi = (exp_of(a) >= exp_of(b)) ? a : b;
        lo = (exp_of(a) >= exp_of(b)) ? b : a;
        diff = exp_of(hi) - exp_of(lo);
        if (diff > 100) begin
            sum = (128'(mant_of(hi)) << 100) + 128'd1;
            return round_pack(1'b0, sum, exp_of(hi) - 100);
        end
        sum = (128'(mant_of(hi)) << diff) + 128'(mant_of(lo));
        return round_pack(1'b0, sum, exp_of(lo));
    endfunction

    // Multiply by a tenth in double precision, then round to single.
    function automatic logic [31:0] next_tenth(input logic [31:0] f);
        logic [127:0] p;
        logic [127:0] q;
        int           ex;
        int           k;
        int           r;
        logic         rest;
        if (f[30:0] == 31'd0) return f;
        p  = 128'(mant_of(f)) * 128'h1999999999999A;
        ex = exp_of(f) - 56;
        k  = 127;
        while (!p[k]) k--;
        if (k > 52) begin
            r    = k - 52;
            q    = p >> r;
            rest = |(p & ((128'd1 << (r - 1)) - 128'd1));
            if (p[r-1] & (rest | q[0])) q = q + 128'd1;
            p  = q;
            ex = ex + r;
        end
        return round_pack(1'b0, p, ex);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic step_pos();
        if (pos < 32'd65535) pos = pos + 32'd1;
    endtask

    task automatic emit_result(input logic [31:0] v, input logic [31:0] cnt);
        logic [31:0] r;
        r = is_nan(v) ? dttf_pkg::F_DNAN : {v[31] ^ neg, v[30:0]};
        expected_results.push_back({cnt[15:0], r});
        ph = P_IDLE;
    endtask

    task automatic scale_by_exponent();
        logic [31:0] e;
        logic [31:0] f;
        e = expo;
        f = fac;
        forever begin
            if (e[0]) acc = f_mul(acc, f);
            e = e >> 1;
            if (e == 32'd0) break;
            f = f_mul(f, f);
        end
    endtask

    task automatic parse_char(input logic [7:0] c, input logic start);
        logic [31:0] d;
        d = {24'd0, c} - 32'd48;
        if (start) begin
            ph = P_WS; acc = 32'd0; fac = dttf_pkg::F_ONE; expo = 32'd0; neg = 1'b0;
            pos = 32'd0;
        end
        if (ph == P_IDLE) return;
        if (ph == P_WS) begin
            if (is_space(c)) begin
                step_pos();
                return;
            end
            if (c == "-" || c == "+") begin
                neg = (c == "-");
                step_pos();
                ph = P_INT;
                return;
            end
            ph = P_INT;
        end
        case (ph)
            P_INT, P_FRAC: begin
                if (is_digit(c)) begin
                    if (ph == P_INT) begin
                        acc = f_add(f_mul(acc, dttf_pkg::F_TEN),
                                    round_pack(1'b0, 128'(d), 0));
                    end else begin
                        fac = next_tenth(fac);
                        acc = f_add(acc, f_mul(round_pack(1'b0, 128'(d), 0), fac));
                    end
                    step_pos();
                end else if (c == "." && ph == P_INT) begin
                    fac = dttf_pkg::F_ONE;
                    step_pos();
                    ph = P_FRAC;
                end else if ((c | 8'd32) == "e") begin
                    fac = dttf_pkg::F_TEN;
                    expo = 32'd0;
                    step_pos();
                    ph = P_ESIGN;
                end else begin
                    emit_result(acc, pos);
                end
            end
            P_ESIGN: begin
                if (c == "-" || c == "+") begin
                    if (c == "-") fac = dttf_pkg::F_TENTH;
                    step_pos();
                    ph = P_EDIG;
                end else if (is_digit(c)) begin
                    expo = d;
                    step_pos();
                    ph = P_EDIG;
                end else begin
                    emit_result(32'd0, 32'd0);
                end
            end
            P_EDIG: begin
                if (is_digit(c)) begin
                    expo = expo * 32'd10 + d;
                    step_pos();
                end else begin
                    scale_by_exponent();
                    emit_result(acc, pos);
                end
            end
            default: ph = P_IDLE;
        endcase
    endtask

    task automatic push_text(input string txt, input logic [7:0] term);
        for (int i = 0; i < txt.len(); i++)
            pending_chars.push_back('{ch: txt[i], start: (i == 0)});
        pending_chars.push_back('{ch: term, start: (txt.len() == 0)});
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    task automatic push_random_string();
        string txt;
        int    n;
        logic [7:0] term;
        txt = "";
        n = $urandom_range(0, 9);
        if (n > 6) repeat ($urandom_range(1, 3))
            txt = {txt, string'(8'($urandom_range(0, 1) ? 32 : $urandom_range(9, 13)))};
        n = $urandom_range(0, 3);
        if (n == 1) txt = {txt, "-"};
        if (n == 2) txt = {txt, "+"};
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 4);
        repeat (n) txt = {txt, string'(rand_digit())};
        if ($urandom_range(0, 1)) begin
            txt = {txt, "."};
            repeat ($urandom_range(0, 6)) txt = {txt, string'(rand_digit())};
        end
        if ($urandom_range(0, 2) == 0) begin
            txt = {txt, $urandom_range(0, 1) ? "e" : "E"};
            n = $urandom_range(0, 4);
            if (n == 1) txt = {txt, "-"};
            if (n == 2) txt = {txt, "+"};
            n = ($urandom_range(0, 14) == 0) ? $urandom_range(3, 11) : $urandom_range(0, 2);
            repeat (n) txt = {txt, string'(rand_digit())};
        end
        case ($urandom_range(0, 4))
            0: term = 8'd0;
            1: term = " ";
            2: term = ",";
            default: term = 8'($urandom_range(0, 255));
        endcase
        if (txt.len() > 0 && $urandom_range(0, 11) == 0)
            txt = txt.substr(0, $urandom_range(0, txt.len() - 1));
        push_text(txt, term);
        repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3))
            pending_chars.push_back('{ch: 8'($urandom_range(0, 255)), start: 1'b0});
    endtask

    task automatic push_noise();
        repeat ($urandom_range(1, 6))
            pending_chars.push_back('{ch: 8'($urandom_range(0, 255)),
                                      start: ($urandom_range(0, 3) == 0)});
    endtask

    function automatic logic sender_waits();
        if (idle_mode == 0) return $urandom_range(0, 99) < 30;
        if (idle_mode == 1) return $urandom_range(0, 99) < 70;
        return 1'b0;
    endfunction

    function automatic logic receiver_waits();
        if (idle_mode == 0) return $urandom_range(0, 99) < 70;
        if (idle_mode == 1) return $urandom_range(0, 99) < 30;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                parse_char(cur_char.ch, cur_char.start);
                accepted++;
                idle_mode = (accepted < stage_len) ? 0 : (accepted < 2 * stage_len) ? 1 : 2;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_chars.size() > 0 && !sender_waits()) begin
                    cur_char = pending_chars.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= cur_char.ch;
                    i_s_tuser <= cur_char.start;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        logic [47:0] want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, o_m_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tdata[31:0] !== want[31:0]) begin
                        $display("%0t: value_bits expected %h actual %h",
                                 $time, want[31:0], o_m_tdata[31:0]);
                        errors++;
                    end
                    if (o_m_tdata[47:32] !== want[47:32]) begin
                        $display("%0t: consumed expected %0d actual %0d",
                                 $time, want[47:32], o_m_tdata[47:32]);
                        errors++;
                    end
                end
            end
            i_m_tready <= !receiver_waits();
        end
    end

    initial begin
        push_text("  -12.5e+3", 8'd0);
        push_text("+", 8'd0);
        push_text("-", "x");
        push_text("\t\n\v\f\r 9", 8'd255);
        push_text("1e", "x");
        push_text("-2E", ";");
        push_text("7e+-", 8'd0);
        push_text("3.", 8'd0);
        push_text(".5", 8'd128);
        push_text("9e99", 8'd0);
        push_text("1e-99", 8'd0);
        push_text("0e1024", 8'd0);
        pending_chars.push_back('{ch: "4", start: 1'b1});
        pending_chars.push_back('{ch: "2", start: 1'b0});
        push_text("6.25", 8'd0);
        pending_chars.push_back('{ch: "5", start: 1'b0});
        push_text("4294967296e1", 8'd0);
        repeat (100) begin
            if ($urandom_range(0, 9) == 0) push_noise();
            else push_random_string();
        end
        stage_len = pending_chars.size() / 3;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_chars.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule
